/* rtl/sorted_range_search_macros.svh */
// Assertion helpers used by the RTL controller (srs_ctrl).
`ifndef SORTED_RANGE_SEARCH_MACROS_SVH
`define SORTED_RANGE_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/srs_pkg.sv */
package srs_pkg;

    localparam int DEF_DEPTH = 1024;
    localparam int VAL_W     = 32;
    localparam int OUT_W     = 11;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic append;     // write word at fill count
        logic clear;      // empty the store
        logic q_start;    // latch key, open first search
        logic rd;         // read store at midpoint
        logic step;       // narrow window on read data
        logic next_pass;  // save first index, open second search
        logic finish;     // save last index
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic more;       // window not empty
        logic pass;       // 1 during the highest-index search
    } t_dp_sts;

endpackage

/* rtl/srs_ram.sv */
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/srs_datapath.sv */
module srs_datapath #(
    parameter int DEPTH = srs_pkg::DEF_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srs_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [srs_pkg::VAL_W-1:0]  i_item_value,
    output srs_pkg::t_dp_sts                  o_sts,
    output logic signed [srs_pkg::OUT_W-1:0]  o_first_index,
    output logic signed [srs_pkg::OUT_W-1:0]  o_last_index
);
    import srs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hx, n_hx;     // exclusive upper bound
    logic                    r_pass, n_pass;
    logic                    r_found, n_found;
    logic [AW-1:0]           r_fidx, n_fidx;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [OUT_W-1:0]        r_first, n_first;
    logic [OUT_W-1:0]        r_last, n_last;

    logic [CW-1:0]           mid;
    logic [CW-1:0]           mid_inc;
    logic [VAL_W-1:0]        rdata;
    logic                    eq, lt;
    logic [AW+OUT_W-1:0]     fidx_ext;
    logic [OUT_W-1:0]        packed_idx;

    assign mid     = r_lo + ((r_hx - r_lo - CW'(1)) >> 1);
    assign mid_inc = mid + CW'(1);

    srs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_item_value),
        .i_re    (i_cmd.rd),
        .i_raddr (mid[AW-1:0]),
        .o_rdata (rdata)
    );

    assign eq = ($signed(rdata) == r_key);
    assign lt = ($signed(rdata) <  r_key);

    assign fidx_ext   = {{OUT_W{1'b0}}, r_fidx};
    assign packed_idx = r_found ? fidx_ext[OUT_W-1:0] : {OUT_W{1'b1}};

    always_comb begin
        n_count = r_count;
        n_lo    = r_lo;
        n_hx    = r_hx;
        n_pass  = r_pass;
        n_found = r_found;
        n_fidx  = r_fidx;
        n_key   = r_key;
        n_first = r_first;
        n_last  = r_last;
        if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.clear) begin
            n_count = '0;
        end
        if (i_cmd.q_start) begin
            n_key   = i_item_value;
            n_lo    = '0;
            n_hx    = r_count;
            n_found = 1'b0;
            n_pass  = 1'b0;
        end
        if (i_cmd.step) begin
            if (eq) begin
                n_found = 1'b1;
                n_fidx  = mid[AW-1:0];
                if (r_pass) begin
                    n_lo = mid_inc;
                end else begin
                    n_hx = mid;
                end
            end else if (lt) begin
                n_lo = mid_inc;
            end else begin
                n_hx = mid;
            end
        end
        if (i_cmd.next_pass) begin
            n_first = packed_idx;
            n_lo    = '0;
            n_hx    = r_count;
            n_found = 1'b0;
            n_pass  = 1'b1;
        end
        if (i_cmd.finish) begin
            n_last = packed_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hx    <= n_hx;
        r_pass  <= n_pass;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_key   <= n_key;
        r_first <= n_first;
        r_last  <= n_last;
    end

    assign o_sts.full    = (r_count == CW'(DEPTH));
    assign o_sts.more    = (r_lo < r_hx);
    assign o_sts.pass    = r_pass;
    assign o_first_index = $signed(r_first);
    assign o_last_index  = $signed(r_last);

endmodule

/* rtl/srs_ctrl.sv */
`include "sorted_range_search_macros.svh"

module srs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_opcode,
    input  srs_pkg::t_dp_sts i_sts,
    output srs_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import srs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_APPEND: o_cmd.append = !i_sts.full;
                        OP_QUERY: begin
                            o_cmd.q_start = 1'b1;
                            n_state       = S_READ;
                        end
                        OP_CLEAR:  o_cmd.clear = 1'b1;
                        default: ;  // unused code, ignored
                    endcase
                end
            end
            S_READ: begin
                if (i_sts.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end else if (!i_sts.pass) begin
                    o_cmd.next_pass = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = S_READ;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    `SRS_ASSERT_NEXT(a_done_one_cycle, r_state == S_DONE, r_state == S_IDLE)
    `SRS_ASSERT_NEXT(a_read_then_cmp, o_cmd.rd, o_cmd.step)
    `SRS_ASSERT_NEXT(a_query_starts, accept && i_opcode == OP_QUERY, o_busy && !o_done)
    `SRS_ASSERT_IMPL(a_no_write_when_full, o_cmd.append, !i_sts.full)

endmodule

/* rtl/sorted_range_search.sv */
// Sorted store with first/last occurrence lookup. Words are appended in
// non-decreasing order (opcode 0), a query (opcode 1) searches for a key and
// a clear (opcode 2) empties the store; opcode 3 is ignored. Append, clear
// and ignored words leave busy low. A query raises busy and runs two binary
// searches on a single store read port, each halving step being a store
// read then a compare, then strobes o_done for one cycle with both indices
// (-1 when the key is absent). The receiver cannot stall, so
// o_first_index/o_last_index must be taken while o_done is high.
// Appends into a full store are dropped silently; order is not checked.
module sorted_range_search #(
    parameter int DEPTH = srs_pkg::DEF_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [1:0]                        i_opcode,
    input  logic signed [srs_pkg::VAL_W-1:0]  i_item_value,
    output logic                              busy,
    output logic                              o_done,
    output logic signed [srs_pkg::OUT_W-1:0]  o_first_index,
    output logic signed [srs_pkg::OUT_W-1:0]  o_last_index
);
    import srs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    srs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    srs_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_item_value  (i_item_value),
        .o_sts         (sts),
        .o_first_index (o_first_index),
        .o_last_index  (o_last_index)
    );

endmodule
